@@ rtl/sta_pkg.sv @@
package sta_pkg;

  // Request codes carried in the req_type field.
  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FIND  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_code_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  // A part number of all ones matches every part on a find.
  localparam logic [7:0] ANY_PART = 8'hFF;

  // Widths of the result fields.
  localparam int unsigned SLOT_IDX_W = 5;
  localparam int unsigned MARK_W     = 6;

  // Request beat.
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] obj_type;
    logic [7:0] obj_part;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic                  hit;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [MARK_W-1:0]     high_water;
  } out_beat_t;

  // Commands from the sequencer to the slot store.
  typedef struct packed {
    logic rd_en;
    logic claim;
    logic free;
  } store_cmd_t;

endpackage

@@ rtl/sta_chan_if.sv @@
interface sta_chan_if #(
  parameter type beat_t = sta_pkg::in_beat_t
);
  logic  valid;
  logic  ready;
  beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/sta_store.sv @@
module sta_store #(
  parameter int unsigned NUM_SLOTS = 32,
  parameter int unsigned IW        = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sta_pkg::store_cmd_t cmd,
  input  logic [IW-1:0]       rd_addr,
  input  logic [IW-1:0]       wr_addr,
  input  logic [7:0]          wr_type,
  input  logic [7:0]          wr_part,
  output logic                rd_occ,
  output logic [7:0]          rd_type,
  output logic [7:0]          rd_part
);

  logic [NUM_SLOTS-1:0] occ_r;
  logic [7:0]           type_mem [NUM_SLOTS];
  logic [7:0]           part_mem [NUM_SLOTS];
  logic                 rd_occ_r;
  logic [7:0]           rd_type_r;
  logic [7:0]           rd_part_r;

  // Occupied flags: cleared by reset, set on a claim, cleared on a free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (cmd.claim) begin
      occ_r[wr_addr] <= 1'b1;
    end else if (cmd.free) begin
      occ_r[wr_addr] <= 1'b0;
    end
  end

  // Type and part memory, written on a claim.
  always_ff @(posedge clk) begin
    if (cmd.claim) begin
      type_mem[wr_addr] <= wr_type;
      part_mem[wr_addr] <= wr_part;
    end
  end

  // Registered read port shared by every scan.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_occ_r  <= occ_r[rd_addr];
      rd_type_r <= type_mem[rd_addr];
      rd_part_r <= part_mem[rd_addr];
    end
  end

  assign rd_occ  = rd_occ_r;
  assign rd_type = rd_type_r;
  assign rd_part = rd_part_r;

endmodule

@@ rtl/sta_ctrl.sv @@
module sta_ctrl #(
  parameter int unsigned NUM_SLOTS = 32,
  parameter int unsigned IW        = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  sta_pkg::in_beat_t    in_beat,
  output logic                 in_ready,
  output logic                 res_valid,
  input  logic                 res_ready,
  output sta_pkg::out_beat_t   res,
  output sta_pkg::store_cmd_t  cmd,
  output logic [IW-1:0]        rd_addr,
  output logic [IW-1:0]        wr_addr,
  output logic [7:0]           wr_type,
  output logic [7:0]           wr_part,
  input  logic                 rd_occ,
  input  logic [7:0]           rd_type,
  input  logic [7:0]           rd_part
);

  localparam logic [IW:0]   CNT_END  = (IW+1)'(NUM_SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  sta_pkg::state_t          state_r, state_nxt;
  logic [IW:0]              cnt_r, cnt_nxt;
  logic                     vld_r, vld_nxt;
  logic [IW-1:0]            idx_r, idx_nxt;
  logic [1:0]               req_r, req_nxt;
  logic [7:0]               type_r, type_nxt;
  logic [7:0]               part_r, part_nxt;
  logic                     hit_r, hit_nxt;
  logic [IW-1:0]            hidx_r, hidx_nxt;
  logic [sta_pkg::MARK_W-1:0] mark_r, mark_nxt;
  logic                     match;
  logic                     last;
  logic                     issue;
  logic                     claim;
  logic                     scan_end;

  // Slot check on the entry read in the previous cycle.
  always_comb begin
    match = 1'b0;
    if (vld_r) begin
      case (req_r)
        sta_pkg::REQ_ALLOC: match = !rd_occ;
        sta_pkg::REQ_FIND:  match = rd_occ && (rd_type == type_r) &&
                                    ((part_r == sta_pkg::ANY_PART) || (rd_part == part_r));
        default:            match = 1'b0;
      endcase
    end
  end

  assign last     = vld_r && (idx_r == LAST_IDX);
  assign scan_end = match || last;
  assign issue    = (state_r == sta_pkg::ST_SCAN) && (cnt_r < CNT_END) && !match;
  assign claim    = (state_r == sta_pkg::ST_SCAN) && match &&
                    (req_r == sta_pkg::REQ_ALLOC);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sta_pkg::ST_IDLE: if (in_valid) state_nxt = sta_pkg::ST_SCAN;
      sta_pkg::ST_SCAN: if (scan_end) state_nxt = sta_pkg::ST_DONE;
      sta_pkg::ST_DONE: if (res_ready) state_nxt = sta_pkg::ST_IDLE;
      default:          state_nxt = sta_pkg::ST_IDLE;
    endcase
  end

  // Handshake and store commands.
  always_comb begin
    in_ready  = (state_r == sta_pkg::ST_IDLE);
    res_valid = (state_r == sta_pkg::ST_DONE);
    cmd.rd_en = issue;
    cmd.claim = claim;
    cmd.free  = (state_r == sta_pkg::ST_SCAN) && vld_r &&
                (req_r == sta_pkg::REQ_CLEAR) &&
                (sta_pkg::MARK_W'(idx_r) < mark_r);
  end

  assign rd_addr = cnt_r[IW-1:0];
  assign wr_addr = idx_r;
  assign wr_type = type_r;
  assign wr_part = part_r;

  // Scan counter, request latch and result capture.
  always_comb begin
    cnt_nxt  = cnt_r;
    vld_nxt  = vld_r;
    idx_nxt  = idx_r;
    req_nxt  = req_r;
    type_nxt = type_r;
    part_nxt = part_r;
    hit_nxt  = hit_r;
    hidx_nxt = hidx_r;
    mark_nxt = mark_r;
    if ((state_r == sta_pkg::ST_IDLE) && in_valid) begin
      cnt_nxt  = '0;
      vld_nxt  = 1'b0;
      req_nxt  = in_beat.req_type;
      type_nxt = in_beat.obj_type;
      part_nxt = in_beat.obj_part;
    end else if (state_r == sta_pkg::ST_SCAN) begin
      cnt_nxt = issue ? cnt_r + 1'b1 : cnt_r;
      vld_nxt = issue;
      idx_nxt = cnt_r[IW-1:0];
      if (scan_end) begin
        hit_nxt  = match;
        hidx_nxt = idx_r;
      end
      // The mark tracks the highest claimed slot plus one.
      if (claim && (sta_pkg::MARK_W'(idx_r) >= mark_r)) begin
        mark_nxt = sta_pkg::MARK_W'(idx_r) + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sta_pkg::ST_IDLE;
      cnt_r   <= '0;
      vld_r   <= 1'b0;
      mark_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      vld_r   <= vld_nxt;
      mark_r  <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    req_r  <= req_nxt;
    type_r <= type_nxt;
    part_r <= part_nxt;
    hit_r  <= hit_nxt;
    hidx_r <= hidx_nxt;
  end

  // Result beat: the index shows only on a hit.
  assign res.hit        = hit_r;
  assign res.slot_index = hit_r ? sta_pkg::SLOT_IDX_W'(hidx_r) : '0;
  assign res.high_water = mark_r;

endmodule

@@ rtl/slot_table_alloc_find.sv @@
// Channel   Dir  Modport  Beat
// in_chan   in   sink     req_type, obj_type, obj_part
// out_chan  out  source   hit, slot_index, high_water
//
// Each request scans the slots one per cycle through a single registered read port
// and one compare unit; an allocate or find stops at the first matching slot, and
// clear always walks every slot.
// The block takes one request at a time; the next is accepted once the result sits
// in the output register, which holds it until the sink takes it.
// Synchronous active-low reset frees every slot and zeroes the high-water mark.
module slot_table_alloc_find #(
  parameter int unsigned NUM_SLOTS = 32
) (
  input logic       clk,
  input logic       rst_n,
  sta_chan_if.sink   in_chan,
  sta_chan_if.source out_chan
);

  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  sta_pkg::store_cmd_t cmd;
  sta_pkg::out_beat_t  res;
  logic                res_valid;
  logic                res_ready;
  logic [IW-1:0]       rd_addr;
  logic [IW-1:0]       wr_addr;
  logic [7:0]          wr_type;
  logic [7:0]          wr_part;
  logic                rd_occ;
  logic [7:0]          rd_type;
  logic [7:0]          rd_part;
  logic                out_valid_r;
  sta_pkg::out_beat_t  out_beat_r;

  sta_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .IW        (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_beat   (in_chan.data),
    .in_ready  (in_chan.ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_type   (wr_type),
    .wr_part   (wr_part),
    .rd_occ    (rd_occ),
    .rd_type   (rd_type),
    .rd_part   (rd_part)
  );

  sta_store #(
    .NUM_SLOTS (NUM_SLOTS),
    .IW        (IW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_type (wr_type),
    .wr_part (wr_part),
    .rd_occ  (rd_occ),
    .rd_type (rd_type),
    .rd_part (rd_part)
  );

  // Output register: loads a finished result whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_beat_r <= res;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_beat_r;

`ifndef SYNTHESIS
  // A hit names a slot that exists.
  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.data.hit) |->
      (sta_pkg::MARK_W'(out_chan.data.slot_index) < NUM_SLOTS || NUM_SLOTS > 32))
    else $error("hit reports a slot beyond the table");

  // A miss reports slot zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.data.hit) |-> (out_chan.data.slot_index == '0))
    else $error("miss with nonzero slot index");

  // The high-water mark never passes the table size.
  a_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.data.high_water <= NUM_SLOTS))
    else $error("high-water mark beyond table size");

  // After accepting a request the block is busy scanning.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("request accepted while a scan is starting");
`endif

endmodule

@@ test/slot_table_alloc_find_checker.sv @@
// Watches both channels of the slot table, keeps its own copy of the table,
// and checks every result beat against the oldest outstanding expectation.
module slot_table_alloc_find_checker #(
  parameter int unsigned NUM_SLOTS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  sta_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  sta_pkg::out_beat_t out_data,
  output int unsigned        fail_count,
  output int unsigned        results_owed
);

  // Shadow copy of the slot table.
  logic                       slot_busy [NUM_SLOTS];
  logic [7:0]                 slot_kind [NUM_SLOTS];
  logic [7:0]                 slot_part [NUM_SLOTS];
  logic [sta_pkg::MARK_W-1:0] water_mark;

  // Results owed by the block, oldest first.
  sta_pkg::out_beat_t owed_q [$];

  // Applies one request to the shadow table and returns the result it must produce.
  function automatic sta_pkg::out_beat_t serve_request(input sta_pkg::in_beat_t rq);
    sta_pkg::out_beat_t res;
    logic               found;
    int unsigned        k;
    res   = '0;
    found = 1'b0;
    case (rq.req_type)
      sta_pkg::REQ_ALLOC: begin
        for (k = 0; k < NUM_SLOTS; k++) begin
          if (!found && !slot_busy[k]) begin
            found          = 1'b1;
            slot_busy[k]   = 1'b1;
            slot_kind[k]   = rq.obj_type;
            slot_part[k]   = rq.obj_part;
            res.slot_index = sta_pkg::SLOT_IDX_W'(k);
            if (k >= water_mark) begin
              water_mark = sta_pkg::MARK_W'(k + 1);
            end
          end
        end
      end
      sta_pkg::REQ_FIND: begin
        // The all-ones part acts as a wildcard on the part compare.
        for (k = 0; k < NUM_SLOTS; k++) begin
          if (!found && slot_busy[k] && slot_kind[k] == rq.obj_type &&
              (rq.obj_part == sta_pkg::ANY_PART || slot_part[k] == rq.obj_part)) begin
            found          = 1'b1;
            res.slot_index = sta_pkg::SLOT_IDX_W'(k);
          end
        end
      end
      sta_pkg::REQ_CLEAR: begin
        // Only slots below the mark are freed; the mark itself stays.
        for (k = 0; k < NUM_SLOTS; k++) begin
          if (k < water_mark) begin
            slot_busy[k] = 1'b0;
          end
        end
      end
      default: begin
        // The unused request code leaves the table alone.
      end
    endcase
    res.hit        = found;
    res.high_water = water_mark;
    return res;
  endfunction

  // Compare result beats first, then record the request beat of the same edge.
  always @(posedge clk) begin
    sta_pkg::out_beat_t want;
    if (!rst_n) begin
      for (int unsigned k = 0; k < NUM_SLOTS; k++) begin
        slot_busy[k] = 1'b0;
      end
      water_mark = '0;
      owed_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: result beat with nothing outstanding: hit=%0d slot=%0d mark=%0d",
                     $time, out_data.hit, out_data.slot_index, out_data.high_water);
          end
          fail_count++;
        end else begin
          want = owed_q.pop_front();
          if (out_data.hit !== want.hit || out_data.slot_index !== want.slot_index ||
              out_data.high_water !== want.high_water) begin
            if (fail_count < 10) begin
              $display("%0t: expected hit=%0d slot=%0d mark=%0d, got hit=%0d slot=%0d mark=%0d",
                       $time, want.hit, want.slot_index, want.high_water,
                       out_data.hit, out_data.slot_index, out_data.high_water);
            end
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        owed_q.push_back(serve_request(in_data));
      end
    end
    results_owed = owed_q.size();
  end

endmodule

@@ test/slot_table_alloc_find_test.sv @@
// Drives request beats into the slot table and gives the verdict; all checking is done
// by the checker instance that sits beside the block.
module slot_table_alloc_find_test;

  localparam int unsigned NUM_SLOTS    = 32;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam int unsigned ITEM_TARGET  = 850;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = NUM_SLOTS + 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned KEY_POOL_MAX = 48;

  logic        clk;
  logic        rst_n;
  logic        hold_go;
  logic        hold_done;
  logic        quiet_phase;
  int unsigned sent_count;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned results_owed;

  // Type and part of recent allocations, used to aim finds at stored slots.
  logic [15:0] key_pool [$];

  sta_chan_if #(.beat_t(sta_pkg::in_beat_t))  req_if ();
  sta_chan_if #(.beat_t(sta_pkg::out_beat_t)) res_if ();

  slot_table_alloc_find #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (req_if),
    .out_chan(res_if)
  );

  slot_table_alloc_find_checker #(
    .NUM_SLOTS(NUM_SLOTS)
  ) table_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req_if.valid),
    .in_ready    (req_if.ready),
    .in_data     (req_if.data),
    .out_valid   (res_if.valid),
    .out_ready   (res_if.ready),
    .out_data    (res_if.data),
    .fail_count  (fail_count),
    .results_owed(results_owed)
  );

  // Clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("slot_table_alloc_find verification failed");
      $finish;
    end
  end

  // Result sink: random stalls, one long hold-off, and a quiet stretch.
  initial begin
    res_if.ready <= 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        res_if.ready <= 1'b0;
        for (int unsigned n = 0; n < HOLD_CYCLES; n++) begin
          @(posedge clk);
        end
      end else begin
        res_if.ready <= rst_n && (quiet_phase || $urandom_range(99) >= 17);
      end
    end
  end

  // Offers one request beat and returns at the edge where it is accepted.
  task automatic offer_request(input logic [1:0] code, input logic [7:0] kind,
                               input logic [7:0] part);
    sta_pkg::in_beat_t beat;
    beat.req_type = code;
    beat.obj_type = kind;
    beat.obj_part = part;
    while (!quiet_phase && $urandom_range(99) < 17) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= beat;
    @(negedge clk);
    while (!req_if.ready) begin
      @(negedge clk);
    end
    @(posedge clk);
    sent_count++;
    if (code == sta_pkg::REQ_ALLOC) begin
      key_pool.push_back({kind, part});
      if (key_pool.size() > KEY_POOL_MAX) begin
        void'(key_pool.pop_front());
      end
    end
    if (sent_count == HOLD_AT) begin
      hold_go = 1'b1;
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int unsigned n_alloc;
    int unsigned n_find;
    logic        narrow;
    logic [15:0] key;
    logic [7:0]  kind;
    logic [7:0]  part;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    rst_n        <= 1'b0;
    hold_go     = 1'b0;
    quiet_phase = 1'b0;
    sent_count  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, each request kind, wildcard part, misses, clears.
    offer_request(sta_pkg::REQ_ALLOC, 8'h00, 8'h00);
    offer_request(sta_pkg::REQ_ALLOC, 8'hFF, 8'hFF);
    offer_request(sta_pkg::REQ_ALLOC, 8'hA5, 8'h5A);
    offer_request(sta_pkg::REQ_ALLOC, 8'h5A, 8'hA5);
    offer_request(sta_pkg::REQ_FIND, 8'h00, 8'h00);
    offer_request(sta_pkg::REQ_FIND, 8'hFF, sta_pkg::ANY_PART);
    offer_request(sta_pkg::REQ_FIND, 8'hA5, sta_pkg::ANY_PART);
    offer_request(sta_pkg::REQ_FIND, 8'h5A, 8'h5A);
    offer_request(sta_pkg::REQ_FIND, 8'h33, sta_pkg::ANY_PART);
    offer_request(sta_pkg::REQ_ALLOC, 8'hA5, 8'h01);
    offer_request(sta_pkg::REQ_FIND, 8'hA5, sta_pkg::ANY_PART);
    offer_request(sta_pkg::REQ_FIND, 8'hA5, 8'h01);
    offer_request(REQ_UNUSED, 8'h12, 8'h34);
    offer_request(sta_pkg::REQ_CLEAR, 8'hFF, 8'hFF);
    offer_request(sta_pkg::REQ_FIND, 8'h00, 8'h00);
    offer_request(sta_pkg::REQ_ALLOC, 8'h77, 8'h88);
    offer_request(sta_pkg::REQ_FIND, 8'h77, sta_pkg::ANY_PART);
    offer_request(sta_pkg::REQ_CLEAR, 8'h00, 8'h00);
    offer_request(sta_pkg::REQ_CLEAR, 8'h00, 8'h00);
    offer_request(REQ_UNUSED, 8'hFF, 8'hFF);

    // Random episodes: a run of allocates, a mix of finds, then usually a clear.
    // The first episode overfills the table so that the full case comes up early.
    n_alloc = NUM_SLOTS + 2;
    while (sent_count < ITEM_TARGET) begin
      quiet_phase = (sent_count >= 400 && sent_count < 560);
      narrow = 1'($urandom_range(1));
      for (int unsigned i = 0; i < n_alloc; i++) begin
        kind = narrow ? 8'($urandom_range(3)) : 8'($urandom);
        part = narrow ? 8'($urandom_range(2)) : 8'($urandom);
        if ($urandom_range(15) == 0) begin
          part = sta_pkg::ANY_PART;
        end
        offer_request(sta_pkg::REQ_ALLOC, kind, part);
      end
      n_find = $urandom_range(20, 2);
      for (int unsigned i = 0; i < n_find; i++) begin
        case ($urandom_range(9))
          0: offer_request(REQ_UNUSED, 8'($urandom), 8'($urandom));
          1: offer_request(sta_pkg::REQ_ALLOC, 8'($urandom_range(3)), 8'($urandom));
          2, 3, 4: begin
            kind = narrow ? 8'($urandom_range(3)) : 8'($urandom);
            part = ($urandom_range(2) == 0) ? sta_pkg::ANY_PART : 8'($urandom_range(2));
            offer_request(sta_pkg::REQ_FIND, kind, part);
          end
          default: begin
            // Aim at something allocated recently, sometimes with the wildcard part.
            key = (key_pool.size() != 0) ? key_pool[$urandom_range(key_pool.size() - 1)]
                                         : 16'($urandom);
            part = ($urandom_range(3) == 0) ? sta_pkg::ANY_PART : key[7:0];
            offer_request(sta_pkg::REQ_FIND, key[15:8], part);
          end
        endcase
      end
      if ($urandom_range(9) < 6) begin
        offer_request(sta_pkg::REQ_CLEAR, 8'($urandom), 8'($urandom));
      end
      n_alloc = ($urandom_range(9) == 0) ? $urandom_range(NUM_SLOTS + 4, NUM_SLOTS)
                                         : $urandom_range(12);
    end
    quiet_phase = 1'b0;
    req_if.valid <= 1'b0;

    // Drain, then allow for a late stray beat.
    @(negedge clk);
    while (results_owed != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("slot_table_alloc_find verification clean");
    end else begin
      $display("slot_table_alloc_find verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/sta_pkg.sv
rtl/sta_chan_if.sv
rtl/sta_store.sv
rtl/sta_ctrl.sv
rtl/slot_table_alloc_find.sv
test/slot_table_alloc_find_checker.sv
test/slot_table_alloc_find_test.sv
